@@ rtl/orf_pkg.sv @@
`timescale 1ns / 1ps
// orf_pkg: shared types and constants of the overwriting ring fifo
// beat payload structs, controller state, command and status structs
// no dependencies
package orf_pkg;

   localparam int ORF_DEPTH         = 16;
   localparam int ORF_ELEMENT_WIDTH = 8;

   localparam int DATA_W  = 8;
   localparam int COUNT_W = 4;
   localparam int SLOTS_W = 5;

   localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;
   localparam logic [SLOTS_W-1:0] SLOTS_MIN   = 5'd2;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef struct packed {
      logic              op;
      logic [DATA_W-1:0] push_data;
   } orf_req_type;

   typedef struct packed {
      logic               ok;
      logic [DATA_W-1:0]  pop_data;
      logic               overwrote;
      logic [COUNT_W-1:0] fill_count;
      logic               is_full;
      logic               is_empty;
   } orf_rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } orf_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic exec;
      logic cfg_write;
   } orf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
   } orf_status_type;

endpackage

@@ rtl/orf_ram.sv @@
`timescale 1ns / 1ps
// orf_ram: generic single write port, single read port ram with registered read
// no dependencies
module orf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/orf_ctrl.sv @@
`timescale 1ns / 1ps
// orf_ctrl: controller state machine of the overwriting ring fifo
// depends on orf_pkg
module orf_ctrl
   import orf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  orf_status_type status,
   output orf_cmd_type    cmd
);

   orf_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !csr_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // register writes win over items when both arrive in idle
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      csr_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = reset || csr_valid;
            csr_ready     = !reset;
            cmd.load_item = !reset && req_valid && !csr_valid;
            cmd.cfg_write = !reset && csr_valid;
         end
         ST_EXEC: begin
            cmd.exec = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

@@ rtl/orf_datapath.sv @@
`timescale 1ns / 1ps
// orf_datapath: ring indices, slot count, slot ram and result register
// depends on orf_pkg and orf_ram
module orf_datapath
   import orf_pkg::*;
#(
   parameter int DEPTH         = ORF_DEPTH,
   parameter int ELEMENT_WIDTH = ORF_ELEMENT_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  orf_cmd_type          cmd,
   output orf_status_type       status,
   input  orf_req_type          req_data,
   input  logic [SLOTS_W-1:0]   csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output orf_rsp_type          rsp_data
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = IW + 1;

   logic [SLOTS_W-1:0]       slots_ff;
   logic [IW-1:0]            wr_idx_ff, wr_idx_in;
   logic [IW-1:0]            rd_idx_ff, rd_idx_in;
   logic                     op_ff;
   logic [DATA_W-1:0]        data_ff;
   orf_rsp_type              rsp_ff, rsp_in;
   logic                     rsp_valid_ff;

   logic [CW-1:0]            slot_n;
   logic [ELEMENT_WIDTH-1:0] ram_rd_data;
   logic [ELEMENT_WIDTH-1:0] ram_wr_data;
   logic                     ram_wr_en;
   logic [ELEMENT_WIDTH+DATA_W-1:0] push_wide;
   logic [ELEMENT_WIDTH+DATA_W-1:0] pop_wide;
   logic [CW-1:0]            cnt;
   logic [CW+COUNT_W-1:0]    cnt_wide;
   logic                     full_before;
   logic                     empty_before;

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i, input logic [CW-1:0] n);
      logic [CW-1:0] j;
      j = {1'b0, i} + CW'(1);
      return (j >= n) ? '0 : j[IW-1:0];
   endfunction

   // slot count in effect: clamped to 2 .. DEPTH
   always_comb begin
      if (slots_ff < SLOTS_MIN) begin
         slot_n = CW'(2);
      end else if (32'(slots_ff) > 32'(DEPTH)) begin
         slot_n = CW'(DEPTH);
      end else begin
         slot_n = CW'(slots_ff);
      end
   end

   assign push_wide   = {{ELEMENT_WIDTH{1'b0}}, data_ff};
   assign ram_wr_data = push_wide[ELEMENT_WIDTH-1:0];
   assign pop_wide    = {{DATA_W{1'b0}}, ram_rd_data};
   assign ram_wr_en   = cmd.exec && (op_ff == OP_PUSH);

   // read port always follows the read index, so the oldest element is ready
   orf_ram #(
      .WIDTH (ELEMENT_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_idx_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      full_before  = next_idx(wr_idx_ff, slot_n) == rd_idx_ff;
      empty_before = wr_idx_ff == rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      rd_idx_in    = rd_idx_ff;
      rsp_in       = '0;
      case (op_ff)
         OP_PUSH: begin
            wr_idx_in     = next_idx(wr_idx_ff, slot_n);
            rsp_in.ok     = 1'b1;
            if (full_before) begin
               rd_idx_in        = next_idx(rd_idx_ff, slot_n);
               rsp_in.overwrote = 1'b1;
            end
         end
         default: begin
            if (!empty_before) begin
               rd_idx_in       = next_idx(rd_idx_ff, slot_n);
               rsp_in.ok       = 1'b1;
               rsp_in.pop_data = pop_wide[DATA_W-1:0];
            end
         end
      endcase
      if (wr_idx_in >= rd_idx_in) begin
         cnt = CW'({1'b0, wr_idx_in} - {1'b0, rd_idx_in});
      end else begin
         cnt = CW'({1'b0, wr_idx_in} + slot_n - {1'b0, rd_idx_in});
      end
      cnt_wide          = {{COUNT_W{1'b0}}, cnt};
      rsp_in.fill_count = cnt_wide[COUNT_W-1:0];
      rsp_in.is_full    = next_idx(wr_idx_in, slot_n) == rd_idx_in;
      rsp_in.is_empty   = wr_idx_in == rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff     <= SLOTS_RESET;
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cfg_write) begin
            slots_ff  <= csr_data;
            wr_idx_ff <= '0;
            rd_idx_ff <= '0;
         end else if (cmd.exec) begin
            wr_idx_ff <= wr_idx_in;
            rd_idx_ff <= rd_idx_in;
         end
         if (cmd.exec) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff   <= req_data.op;
         data_ff <= req_data.push_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule

@@ rtl/overwriting_ring_fifo_top.sv @@
`timescale 1ns / 1ps
// overwriting_ring_fifo_top: top level of the overwriting ring fifo
// depends on orf_pkg, orf_ctrl, orf_datapath, orf_ram
//
// ring fifo over csr_data slots (clamped to 2 .. DEPTH, reset 16), holding at
// most one less element than slots. each req beat is a push or a pop and gives
// exactly one rsp beat with ok, popped data, overwrite flag, fill count and the
// full and empty flags after the operation. a push always succeeds; on a full
// fifo it drops the oldest element and sets overwrote. a pop on an empty fifo
// returns ok low, zero data and leaves the state alone. an item passes through
// an accept cycle, in which the slot ram's registered read port
// fetches the oldest element, and an execute cycle that updates the indices,
// writes the ram on a push and loads the result register. the execute cycle
// holds while a previous result still stalls in the result register, so a new
// beat is taken while an older result waits. writing the csr (only while idle)
// sets the slot count and empties the fifo; csr writes take priority over a
// req beat offered in the same cycle. slot contents are not cleared by reset.
module overwriting_ring_fifo_top
   import orf_pkg::*;
#(
   parameter int DEPTH         = ORF_DEPTH,
   parameter int ELEMENT_WIDTH = ORF_ELEMENT_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  orf_req_type        req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output orf_rsp_type        rsp_data,
   // slot count register
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SLOTS_W-1:0] csr_data
);

   orf_cmd_type    cmd;
   orf_status_type status;

   // sequencing of accept, execute and csr beats
   orf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // indices, slot ram and result register
   orf_datapath #(
      .DEPTH         (DEPTH),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/orf_checker.sv @@
`timescale 1ns / 1ps
// orf_checker: port level assertions of the overwriting ring fifo, bound to the top
// depends on orf_pkg and overwriting_ring_fifo_top
module orf_checker
   import orf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input orf_rsp_type rsp_data
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp beat changed");

   // block is busy in the cycle after taking a beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req beat taken in back to back cycles");

   // a failed operation is a pop on an empty fifo and returns no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.is_empty && rsp_data.pop_data == '0
                                    && !rsp_data.overwrote)
      else $error("failed op with non empty fifo or data");

   // an overwrite leaves the fifo full
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overwrote |-> rsp_data.ok && rsp_data.is_full)
      else $error("overwrite without full fifo");

   // full and empty never together
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.is_full && rsp_data.is_empty))
      else $error("full and empty both set");

endmodule

bind overwriting_ring_fifo_top orf_checker u_orf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
